/* hw/rtl/ucs_pkg.sv */
// ucs_pkg: shared types, constants and codes for the uri component splitter
// used by ucs_front, ucs_queue, ucs_back and uri_component_splitter
// no dependencies
package ucs_pkg;

   // longest text tracked, and offset width able to hold 0..MAX_LEN
   localparam int MAX_LEN = 256;
   localparam int OFS_W   = $clog2(MAX_LEN + 1);
   localparam logic [OFS_W-1:0] NONE_OFS = OFS_W'(MAX_LEN);

   // result field widths
   localparam int COMP_W  = 3;
   localparam int START_W = 8;
   localparam int LEN_W   = 9;

   // summary queue depth between front and back
   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   // delimiter bytes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_AT    = 8'h40;

   // component codes
   localparam logic [COMP_W-1:0] COMP_SCHEME   = 3'd0;
   localparam logic [COMP_W-1:0] COMP_USER     = 3'd1;
   localparam logic [COMP_W-1:0] COMP_PASSWORD = 3'd2;
   localparam logic [COMP_W-1:0] COMP_HOST     = 3'd3;
   localparam logic [COMP_W-1:0] COMP_PORT     = 3'd4;
   localparam logic [COMP_W-1:0] COMP_PATH     = 3'd5;
   localparam logic [COMP_W-1:0] COMP_QUERY    = 3'd6;
   localparam logic [COMP_W-1:0] COMP_FRAGMENT = 3'd7;

   // progress through the "//" after the scheme colon
   typedef enum logic [1:0] {
      SP_WAIT_FIRST,
      SP_WAIT_SECOND,
      SP_GOOD,
      SP_BAD
   } spc_type;

   // delimiter positions gathered over one uri
   typedef struct packed {
      logic [OFS_W-1:0] len;
      logic             leading;
      logic [OFS_W-1:0] hash;
      logic [OFS_W-1:0] question;
      logic [OFS_W-1:0] colon;
      spc_type          spc;
      logic [OFS_W-1:0] path;
      logic [OFS_W-1:0] at;
      logic [OFS_W-1:0] cba;
      logic [OFS_W-1:0] caa;
   } summary_type;

   localparam summary_type SUMMARY_CLEAR = '{
      len:      '0,
      leading:  1'b0,
      hash:     NONE_OFS,
      question: NONE_OFS,
      colon:    NONE_OFS,
      spc:      SP_WAIT_FIRST,
      path:     NONE_OFS,
      at:       NONE_OFS,
      cba:      NONE_OFS,
      caa:      NONE_OFS
   };

   // component boundaries worked out from a summary
   typedef struct packed {
      logic             ok;
      logic             leading;
      logic [OFS_W-1:0] len;
      logic [OFS_W-1:0] hash;
      logic [OFS_W-1:0] question;
      logic [OFS_W-1:0] colon;
      logic [OFS_W-1:0] path;
      logic [OFS_W-1:0] at;
      logic [OFS_W-1:0] cba;
      logic [OFS_W-1:0] t_end;
      logic [OFS_W-1:0] t_q;
      logic [OFS_W-1:0] t_a;
      logic [OFS_W-1:0] a0;
      logic [OFS_W-1:0] h0;
      logic [OFS_W-1:0] pc;
   } bounds_type;

   // queue status seen by the front
   typedef struct packed {
      logic full;
      logic valid;
   } qstat_type;

endpackage

/* hw/rtl/uri_component_splitter.sv */
// uri_component_splitter: top level of the uri component splitter
// instantiates ucs_front, ucs_queue and ucs_back; depends on ucs_pkg
//
// Usage: the request channel carries one uri byte per beat in req_tdata[7:0],
// with req_tlast on the final byte of each uri. A zero byte, or any byte past
// 256, ends the text; later bytes are ignored until req_tlast. For every uri
// the response channel carries eight records in component order (scheme,
// user, password, host, port, path, query, fragment), rsp_tlast on the eighth.
// Throughput: one request per cycle while req_tready is high, set by the front
// tracker, which does all per-byte work combinationally. The back emits one
// record per cycle while the receiver is ready; uris shorter than 8 bytes keep
// the back busy and fill the two-entry summary queue, after which req_tready drops.
// The final byte's summary goes into the queue, then the back's slot, then its
// first record is registered; the other seven follow while rsp_tready holds.
// A stalled receiver holds the registered record; the back stops, the queue
// fills, and only then are requests refused. Reset (synchronous, active
// high) clears the tracker, the queue and the output stage; no clearing pass.
module uri_component_splitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] component, [3] present, [11:4] start_offset,
                                    // [20:12] length, [21] ok, [23:22] zero
   output logic        rsp_tlast    // last_record
);

   ucs_pkg::summary_type push_data;
   ucs_pkg::summary_type pop_data;
   ucs_pkg::qstat_type   q_status;
   logic                 push;
   logic                 pop;
   logic                 in_accept;

   logic [ucs_pkg::COMP_W-1:0]  comp;
   logic                        present;
   logic [ucs_pkg::START_W-1:0] start_ofs;
   logic [ucs_pkg::LEN_W-1:0]   len;
   logic                        ok;

   assign req_tready = !q_status.full;
   assign in_accept  = req_tvalid && req_tready;

   // byte tracker
   ucs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_char   (req_tdata),
      .in_last   (req_tlast),
      .push      (push),
      .push_data (push_data)
   );

   // summary queue
   ucs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // record generator
   ucs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_status.valid),
      .q_data      (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_comp    (comp),
      .rsp_present (present),
      .rsp_start   (start_ofs),
      .rsp_len     (len),
      .rsp_ok      (ok),
      .rsp_last    (rsp_tlast)
   );

   // response packing
   assign rsp_tdata = {2'b00, ok, len, start_ofs, present, comp};

endmodule

/* hw/rtl/ucs_front.sv */
// ucs_front: takes uri bytes and records first positions of each delimiter
// pushes one summary per uri into the queue on the final byte
// depends on ucs_pkg
module ucs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_accept,
   input  logic [7:0]           in_char,
   input  logic                 in_last,
   output logic                 push,
   output ucs_pkg::summary_type push_data
);

   logic                 ended_ff, ended_in;
   ucs_pkg::summary_type sum_ff, sum_in;
   ucs_pkg::summary_type nxt;
   logic                 ended_nxt;
   logic [ucs_pkg::OFS_W-1:0] pos;

   // per-byte delimiter tracking
   always_comb begin
      nxt       = sum_ff;
      ended_nxt = ended_ff;
      pos       = sum_ff.len;
      if (!ended_ff) begin
         if (in_char == ucs_pkg::CH_NUL || pos >= ucs_pkg::NONE_OFS) begin
            ended_nxt = 1'b1;
         end else begin
            nxt.len = pos + 1'b1;
            priority if (sum_ff.hash != ucs_pkg::NONE_OFS) begin
            end else if (in_char == ucs_pkg::CH_HASH) begin
               nxt.hash = pos;
            end else if (sum_ff.question != ucs_pkg::NONE_OFS) begin
            end else if (in_char == ucs_pkg::CH_QUEST) begin
               nxt.question = pos;
            end else if (pos == '0 && in_char == ucs_pkg::CH_SLASH) begin
               nxt.leading = 1'b1;
            end else if (sum_ff.leading) begin
            end else if (sum_ff.colon == ucs_pkg::NONE_OFS) begin
               if (in_char == ucs_pkg::CH_COLON) nxt.colon = pos;
            end else if (sum_ff.spc == ucs_pkg::SP_WAIT_FIRST) begin
               nxt.spc = (in_char == ucs_pkg::CH_SLASH) ? ucs_pkg::SP_WAIT_SECOND
                                                        : ucs_pkg::SP_BAD;
            end else if (sum_ff.spc == ucs_pkg::SP_WAIT_SECOND) begin
               nxt.spc = (in_char == ucs_pkg::CH_SLASH) ? ucs_pkg::SP_GOOD
                                                        : ucs_pkg::SP_BAD;
            end else if (sum_ff.spc != ucs_pkg::SP_GOOD) begin
            end else if (sum_ff.path != ucs_pkg::NONE_OFS) begin
            end else if (in_char == ucs_pkg::CH_SLASH) begin
               nxt.path = pos;
            end else if (sum_ff.at == ucs_pkg::NONE_OFS) begin
               if (in_char == ucs_pkg::CH_AT) begin
                  nxt.at = pos;
               end else if (in_char == ucs_pkg::CH_COLON && sum_ff.cba == ucs_pkg::NONE_OFS) begin
                  nxt.cba = pos;
               end
            end else if (in_char == ucs_pkg::CH_COLON && sum_ff.caa == ucs_pkg::NONE_OFS) begin
               nxt.caa = pos;
            end
         end
      end
   end

   // state update, cleared after the final byte
   always_comb begin
      sum_in    = sum_ff;
      ended_in  = ended_ff;
      push      = 1'b0;
      push_data = nxt;
      if (in_accept) begin
         if (in_last) begin
            sum_in   = ucs_pkg::SUMMARY_CLEAR;
            ended_in = 1'b0;
            push     = 1'b1;
         end else begin
            sum_in   = nxt;
            ended_in = ended_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= ucs_pkg::SUMMARY_CLEAR;
         ended_ff <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         ended_ff <= ended_in;
      end
   end

endmodule

/* hw/rtl/ucs_queue.sv */
// ucs_queue: short fifo of uri summaries between front and back
// depends on ucs_pkg
module ucs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ucs_pkg::summary_type push_data,
   input  logic                 pop,
   output ucs_pkg::summary_type pop_data,
   output ucs_pkg::qstat_type   status
);

   ucs_pkg::summary_type entry_ff [ucs_pkg::Q_DEPTH];
   logic [ucs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ucs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ucs_pkg::QCNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == ucs_pkg::QCNT_W'(ucs_pkg::Q_DEPTH));
   assign status.valid = (count_ff != '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ucs_pkg::QPTR_W'(ucs_pkg::Q_DEPTH - 1)) ? '0
                                                                           : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ucs_pkg::QPTR_W'(ucs_pkg::Q_DEPTH - 1)) ? '0
                                                                           : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/ucs_back.sv */
// ucs_back: turns a uri summary into component bounds, then emits eight records
// one record per cycle while the receiver is ready, through a registered output stage
// depends on ucs_pkg
module ucs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  ucs_pkg::summary_type          q_data,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ucs_pkg::COMP_W-1:0]    rsp_comp,
   output logic                          rsp_present,
   output logic [ucs_pkg::START_W-1:0]   rsp_start,
   output logic [ucs_pkg::LEN_W-1:0]     rsp_len,
   output logic                          rsp_ok,
   output logic                          rsp_last
);

   localparam int OW = ucs_pkg::OFS_W;

   ucs_pkg::bounds_type bnd;
   ucs_pkg::bounds_type slot_ff, slot_in;
   logic                slot_valid_ff, slot_valid_in;
   logic [ucs_pkg::COMP_W-1:0] idx_ff, idx_in;

   logic                         out_valid_ff, out_valid_in;
   logic [ucs_pkg::COMP_W-1:0]   out_comp_ff, out_comp_in;
   logic                         out_present_ff, out_present_in;
   logic [ucs_pkg::START_W-1:0]  out_start_ff, out_start_in;
   logic [ucs_pkg::LEN_W-1:0]    out_len_ff, out_len_in;
   logic                         out_ok_ff, out_ok_in;
   logic                         out_last_ff, out_last_in;

   logic          out_load;
   logic          slot_free;
   logic [OW:0]   c_ext;
   logic          has_at;
   logic          net_ok;
   logic          rec_pres;
   logic [OW-1:0] seg_lo;
   logic [OW-1:0] seg_hi;
   logic [OW-1:0] seg_len;

   // boundaries of the uri at the queue head
   always_comb begin
      c_ext        = {1'b0, q_data.colon} + (OW + 1)'(3);
      has_at       = (q_data.at != ucs_pkg::NONE_OFS);
      bnd.leading  = q_data.leading;
      bnd.len      = q_data.len;
      bnd.hash     = q_data.hash;
      bnd.question = q_data.question;
      bnd.colon    = q_data.colon;
      bnd.path     = q_data.path;
      bnd.at       = q_data.at;
      bnd.cba      = q_data.cba;
      bnd.t_end    = (q_data.hash != ucs_pkg::NONE_OFS) ? q_data.hash : q_data.len;
      bnd.t_q      = (q_data.question != ucs_pkg::NONE_OFS) ? q_data.question : bnd.t_end;
      bnd.t_a      = (q_data.path != ucs_pkg::NONE_OFS) ? q_data.path : bnd.t_q;
      bnd.a0       = c_ext[OW-1:0];
      bnd.h0       = has_at ? q_data.at + 1'b1 : bnd.a0;
      bnd.pc       = has_at ? q_data.caa : q_data.cba;
      net_ok       = (q_data.colon != ucs_pkg::NONE_OFS) && (q_data.colon != '0)
                     && (q_data.spc == ucs_pkg::SP_GOOD) && ({1'b0, bnd.t_q} > c_ext)
                     && !(has_at && q_data.at == bnd.a0) && (bnd.h0 < bnd.t_a);
      bnd.ok       = q_data.leading || net_ok;
   end

   // handshake between slot, queue and output stage
   assign out_load  = slot_valid_ff && (!out_valid_ff || rsp_ready);
   assign slot_free = !slot_valid_ff || (out_load && idx_ff == ucs_pkg::COMP_FRAGMENT);
   assign pop       = q_valid && slot_free;

   // span of the current component
   always_comb begin
      rec_pres = 1'b0;
      seg_lo   = '0;
      seg_hi   = '0;
      unique case (idx_ff)
         ucs_pkg::COMP_SCHEME: begin
            rec_pres = !slot_ff.leading;
            seg_hi   = slot_ff.colon;
         end
         ucs_pkg::COMP_USER: begin
            rec_pres = !slot_ff.leading && slot_ff.at != ucs_pkg::NONE_OFS;
            seg_lo   = slot_ff.a0;
            seg_hi   = (slot_ff.cba != ucs_pkg::NONE_OFS) ? slot_ff.cba : slot_ff.at;
         end
         ucs_pkg::COMP_PASSWORD: begin
            rec_pres = !slot_ff.leading && slot_ff.at != ucs_pkg::NONE_OFS
                       && slot_ff.cba != ucs_pkg::NONE_OFS;
            seg_lo   = slot_ff.cba + 1'b1;
            seg_hi   = slot_ff.at;
         end
         ucs_pkg::COMP_HOST: begin
            rec_pres = !slot_ff.leading;
            seg_lo   = slot_ff.h0;
            seg_hi   = (slot_ff.pc != ucs_pkg::NONE_OFS) ? slot_ff.pc : slot_ff.t_a;
         end
         ucs_pkg::COMP_PORT: begin
            rec_pres = !slot_ff.leading && slot_ff.pc != ucs_pkg::NONE_OFS;
            seg_lo   = slot_ff.pc + 1'b1;
            seg_hi   = slot_ff.t_a;
         end
         ucs_pkg::COMP_PATH: begin
            rec_pres = slot_ff.leading || slot_ff.path != ucs_pkg::NONE_OFS;
            seg_lo   = slot_ff.leading ? OW'(1) : slot_ff.path + 1'b1;
            seg_hi   = slot_ff.t_q;
         end
         ucs_pkg::COMP_QUERY: begin
            rec_pres = slot_ff.question != ucs_pkg::NONE_OFS;
            seg_lo   = slot_ff.question + 1'b1;
            seg_hi   = slot_ff.t_end;
         end
         ucs_pkg::COMP_FRAGMENT: begin
            rec_pres = slot_ff.hash != ucs_pkg::NONE_OFS;
            seg_lo   = slot_ff.hash + 1'b1;
            seg_hi   = slot_ff.len;
         end
         default: begin
            rec_pres = 1'b0;
         end
      endcase
      seg_len = seg_hi - seg_lo;
   end

   // slot and record sequencing
   always_comb begin
      slot_in        = slot_ff;
      slot_valid_in  = slot_valid_ff;
      idx_in         = idx_ff;
      out_valid_in   = out_valid_ff;
      out_comp_in    = out_comp_ff;
      out_present_in = out_present_ff;
      out_start_in   = out_start_ff;
      out_len_in     = out_len_ff;
      out_ok_in      = out_ok_ff;
      out_last_in    = out_last_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in   = 1'b1;
         out_comp_in    = idx_ff;
         out_present_in = slot_ff.ok && rec_pres;
         out_start_in   = (slot_ff.ok && rec_pres) ? ucs_pkg::START_W'(seg_lo) : '0;
         out_len_in     = (slot_ff.ok && rec_pres) ? ucs_pkg::LEN_W'(seg_len) : '0;
         out_ok_in      = slot_ff.ok;
         out_last_in    = (idx_ff == ucs_pkg::COMP_FRAGMENT);
         idx_in         = idx_ff + 1'b1;
      end
      if (slot_free) begin
         slot_valid_in = 1'b0;
      end
      if (pop) begin
         slot_valid_in = 1'b1;
         slot_in       = bnd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         idx_ff        <= ucs_pkg::COMP_SCHEME;
         out_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      out_comp_ff    <= out_comp_in;
      out_present_ff <= out_present_in;
      out_start_ff   <= out_start_in;
      out_len_ff     <= out_len_in;
      out_ok_ff      <= out_ok_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_comp    = out_comp_ff;
   assign rsp_present = out_present_ff;
   assign rsp_start   = out_start_ff;
   assign rsp_len     = out_len_ff;
   assign rsp_ok      = out_ok_ff;
   assign rsp_last    = out_last_ff;

   // the closing record of a run is always the fragment
   a_last_is_fragment: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_last_ff == (out_comp_ff == ucs_pkg::COMP_FRAGMENT)))
      else $error("last record flag does not match fragment component");

   // a failed parse reports no component
   a_fail_absent: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ok_ff |-> !out_present_ff && out_len_ff == '0)
      else $error("component present on a failed parse");

   // a run in progress keeps its slot
   a_idx_in_slot: assert property (@(posedge clock) disable iff (reset)
      idx_ff != ucs_pkg::COMP_SCHEME |-> slot_valid_ff)
      else $error("record index advanced without a loaded slot");

   // records of one run come out in component order
   a_comp_order: assert property (@(posedge clock) disable iff (reset)
      out_load && $past(out_load) && !$past(reset) && idx_ff != ucs_pkg::COMP_SCHEME
      |-> out_comp_ff == idx_ff - 1'b1)
      else $error("records left out of component order");

endmodule
